@@ rtl/fqs_pkg.sv @@
package fqs_pkg;

    // Default ring depth
    localparam int DEPTH_DEF = 16;

    // Request codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // capture request
        logic push;        // write tail entry, advance tail
        logic pop;         // advance head
        logic take_rd;     // capture read word as result data
        logic scan_start;  // start search at head
        logic scan_next;   // step search to next entry
        logic found;       // record match position
        logic load_out;    // move result into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       match;
        logic       scan_last;
        logic       out_free;
    } stat_t;

endpackage

@@ rtl/fqs_ctrl.sv @@
module fqs_ctrl
    import fqs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.op)
                    OP_PUSH: begin
                        cmd.push   = !stat.full;
                        state_next = ST_RESULT;
                    end
                    OP_POP, OP_PEEK: begin
                        // head word is read this cycle
                        state_next = stat.empty ? ST_RESULT : ST_READ;
                    end
                    default: begin
                        if (stat.empty) begin
                            state_next = ST_RESULT;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_READ: begin
                cmd.take_rd = 1'b1;
                cmd.pop     = (stat.op == OP_POP);
                state_next  = ST_RESULT;
            end
            ST_SCAN: begin
                if (stat.match) begin
                    cmd.found  = 1'b1;
                    state_next = ST_RESULT;
                end else if (stat.scan_last) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/fqs_dpath.sv @@
module fqs_dpath
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] in_data,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic        [IDX_W-1:0]   rd_addr;

    logic        [1:0]         op_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic        [IDX_W-1:0]   head_reg;
    logic        [IDX_W-1:0]   tail_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic        [IDX_W-1:0]   scan_idx_reg;
    logic        [IDX_W-1:0]   scan_i_reg;

    logic                      res_ok_reg;
    logic signed [VALUE_W-1:0] res_data_reg;
    logic        [POS_W-1:0]   res_pos_reg;

    logic                      out_valid_reg;
    logic                      out_ok_reg;
    logic signed [VALUE_W-1:0] out_data_reg;
    logic        [POS_W-1:0]   out_pos_reg;
    logic                      out_empty_reg;
    logic        [COUNT_W-1:0] out_count_reg;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    // Reads follow the head unless the search is stepping
    assign rd_addr = cmd.scan_next ? ring_inc(scan_idx_reg) : head_reg;

    assign stat.op        = op_reg;
    assign stat.full      = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty     = (cnt_reg == '0);
    assign stat.match     = (rd_data_reg == val_reg);
    assign stat.scan_last = ((CNT_W'(scan_i_reg) + CNT_W'(1)) == cnt_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= val_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                tail_reg <= ring_inc(tail_reg);
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            if (cmd.pop) begin
                head_reg <= ring_inc(head_reg);
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg       <= in_data[1:0];
            val_reg      <= in_data[VALUE_W+1:2];
            res_ok_reg   <= 1'b0;
            res_data_reg <= '0;
            res_pos_reg  <= '0;
        end
        if (cmd.push) begin
            res_ok_reg <= 1'b1;
        end
        if (cmd.take_rd) begin
            res_ok_reg   <= 1'b1;
            res_data_reg <= rd_data_reg;
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= head_reg;
            scan_i_reg   <= '0;
        end
        if (cmd.scan_next) begin
            scan_idx_reg <= ring_inc(scan_idx_reg);
            scan_i_reg   <= scan_i_reg + IDX_W'(1);
        end
        if (cmd.found) begin
            res_ok_reg  <= 1'b1;
            res_pos_reg <= POS_W'(scan_i_reg);
        end
        if (cmd.load_out) begin
            out_ok_reg    <= res_ok_reg;
            out_data_reg  <= res_data_reg;
            out_pos_reg   <= res_pos_reg;
            out_empty_reg <= (cnt_reg == '0);
            out_count_reg <= COUNT_W'(cnt_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_count_reg, out_empty_reg, out_pos_reg, out_data_reg, out_ok_reg};

endmodule

@@ rtl/fifo_queue_with_search.sv @@
// Channel | Ports                                 | Payload
// --------+---------------------------------------+-----------------------------------
// request | s_axis_tvalid/tready/tdata[39:0]      | opcode, value
// result  | m_axis_tvalid/tready/tdata[47:0]      | ok, data, position, is_empty, count
//
// One request at a time; a new request is taken only once the last result has entered
// the output register. A search visits one entry per cycle, a rate set by the single
// read port of the entry memory. Synchronous active-low reset empties the queue;
// entries are not cleared. A stalled result holds in the output register and blocks
// the next request only once its own result is ready.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // opcode[1:0], value[33:2], zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // ok[0], data[32:1], position[36:33],
                                                // is_empty[37], count[42:38], zero pad
);

    cmd_t  cmd;
    stat_t stat;

    fqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fqs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_axis_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/fqs_check.sv @@
module fqs_check
    import fqs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Only one request in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready held after request transfer");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[37] == (m_axis_tdata[42:38] == 5'd0)))
        else $error("is_empty disagrees with count");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |->
            (m_axis_tdata[32:1] == 32'd0) && (m_axis_tdata[36:33] == 4'd0))
        else $error("failed result carries data or position");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind fifo_queue_with_search fqs_check u_check (.*);
